// ----- src/fps_pkg.sv -----
// shared constants, types and state codes for the fitness-proportionate selector
// no dependencies; every other file of the block depends on this package
package fps_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int WEIGHT_BITS = 16;
   localparam int RANDOM_BITS = 16;

   localparam int IDX_BITS  = $clog2(MAX_ENTRIES);
   localparam int CNT_BITS  = $clog2(MAX_ENTRIES + 1);
   localparam int SUM_BITS  = WEIGHT_BITS + CNT_BITS;
   localparam int PROD_BITS = RANDOM_BITS + SUM_BITS;

   localparam int CFG_BITS          = 8;
   localparam int ENTRY_COUNT_RESET = 100;
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;

   // register index, taken from paddr[2]
   localparam logic REG_ENTRY_COUNT = 1'b0;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_MUL,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FINISH
   } fps_state_type;

   typedef struct packed {
      logic                wr_en;
      logic                start;
      logic                rd_en;
      logic [IDX_BITS-1:0] addr;
      logic                sum_add;
      logic                mul;
      logic                cum_add;
      logic                out_load;
   } fps_cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic hit;
   } fps_stat_type;

endpackage

// ----- src/fps_if.sv -----
// handshake channels of the selector: request word in, response word out
// depends on fps_pkg for field widths
interface fps_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [fps_pkg::IDX_BITS-1:0]    entry_index;
   logic [fps_pkg::WEIGHT_BITS-1:0] weight_value;
   logic [fps_pkg::RANDOM_BITS-1:0] random_fraction;

   modport source (output valid, req_type, entry_index, weight_value, random_fraction,
                   input ready);
   modport sink   (input valid, req_type, entry_index, weight_value, random_fraction,
                   output ready);
endinterface

interface fps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fps_pkg::IDX_BITS-1:0] selected_index;
   logic                        all_zero_flag;

   modport source (output valid, selected_index, all_zero_flag, input ready);
   modport sink   (input valid, selected_index, all_zero_flag, output ready);
endinterface

// ----- src/fps_datapath.sv -----
// weight memory, sum and cumulative accumulators, threshold multiplier, result registers
// depends on fps_pkg; driven by commands from fps_ctrl
module fps_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  fps_pkg::fps_cmd_type            cmd,
   output fps_pkg::fps_stat_type           stat,
   input  logic [fps_pkg::IDX_BITS-1:0]    req_entry_index,
   input  logic [fps_pkg::WEIGHT_BITS-1:0] req_weight_value,
   input  logic [fps_pkg::RANDOM_BITS-1:0] req_random_fraction,
   output logic [fps_pkg::IDX_BITS-1:0]    rsp_selected_index,
   output logic                            rsp_all_zero_flag
);
   import fps_pkg::*;

   logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [WEIGHT_BITS-1:0] mem_rd_ff;
   logic                   rd_vld_ff;
   logic [WEIGHT_BITS-1:0] rd_data;

   logic [RANDOM_BITS-1:0] frac_ff, frac_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SUM_BITS-1:0]    thr_ff, thr_in;
   logic [SUM_BITS-1:0]    cum_ff, cum_in;
   logic [PROD_BITS-1:0]   product;
   logic [IDX_BITS-1:0]    res_idx_ff, res_idx_in;
   logic                   res_zero_ff, res_zero_in;
   logic [IDX_BITS-1:0]    out_idx_ff, out_idx_in;
   logic                   out_zero_ff, out_zero_in;

   // weight memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[req_entry_index] <= req_weight_value;
      end
      if (cmd.rd_en) begin
         mem_rd_ff <= mem[cmd.addr];
         rd_vld_ff <= valid_ff[cmd.addr];
      end
   end

   // entries never written since reset read as zero
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[req_entry_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_vld_ff ? mem_rd_ff : '0;
   assign product = PROD_BITS'(frac_ff) * PROD_BITS'(sum_ff);

   always_comb begin
      frac_in     = frac_ff;
      sum_in      = sum_ff;
      thr_in      = thr_ff;
      cum_in      = cum_ff;
      res_idx_in  = res_idx_ff;
      res_zero_in = res_zero_ff;
      out_idx_in  = out_idx_ff;
      out_zero_in = out_zero_ff;
      if (cmd.start) begin
         frac_in = req_random_fraction;
         sum_in  = '0;
      end
      if (cmd.sum_add) begin
         sum_in = sum_ff + SUM_BITS'(rd_data);
      end
      if (cmd.mul) begin
         thr_in      = product[PROD_BITS-1:RANDOM_BITS];
         cum_in      = '0;
         res_idx_in  = '0;
         res_zero_in = (sum_ff == '0);
      end
      if (cmd.cum_add) begin
         cum_in = cum_ff + SUM_BITS'(rd_data);
         if (stat.hit) begin
            res_idx_in = cmd.addr;
         end
      end
      if (cmd.out_load) begin
         out_idx_in  = res_idx_ff;
         out_zero_in = res_zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff     <= frac_in;
      sum_ff      <= sum_in;
      thr_ff      <= thr_in;
      cum_ff      <= cum_in;
      res_idx_ff  <= res_idx_in;
      res_zero_ff <= res_zero_in;
      out_idx_ff  <= out_idx_in;
      out_zero_ff <= out_zero_in;
   end

   assign stat.sum_zero = (sum_ff == '0);
   assign stat.hit      = (cum_ff + SUM_BITS'(rd_data)) > thr_ff;

   assign rsp_selected_index = out_idx_ff;
   assign rsp_all_zero_flag  = out_zero_ff;

endmodule

// ----- src/fps_ctrl.sv -----
// sequencer for load and draw words: sum pass, threshold, scan pass, result hand-off
// depends on fps_pkg; drives fps_datapath through the command struct
module fps_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [fps_pkg::CFG_BITS-1:0] entry_count,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output fps_pkg::fps_cmd_type         cmd,
   input  fps_pkg::fps_stat_type        stat
);
   import fps_pkg::*;

   fps_state_type       state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CNT_BITS-1:0] cnt_nxt;
   logic [CNT_BITS-1:0] count_sat;
   logic                last;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                out_free;

   assign count_sat = (entry_count > CFG_BITS'(MAX_ENTRIES)) ? CNT_BITS'(MAX_ENTRIES)
                                                              : CNT_BITS'(entry_count);
   assign cnt_nxt   = cnt_ff + 1'b1;
   assign last      = (cnt_nxt >= count_sat);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_DRAW) begin
               state_in = (count_sat == '0) ? ST_MUL : ST_SUM_RD;
            end
         end
         ST_SUM_RD:  state_in = ST_SUM_ACC;
         ST_SUM_ACC: state_in = last ? ST_MUL : ST_SUM_RD;
         ST_MUL:     state_in = stat.sum_zero ? ST_FINISH : ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            state_in = (stat.hit || last) ? ST_FINISH : ST_SCAN_RD;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.addr     = cnt_ff[IDX_BITS-1:0];
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_en = (req_type == REQ_LOAD);
               cmd.start = (req_type == REQ_DRAW);
               cnt_in    = '0;
            end
         end
         ST_SUM_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_SUM_ACC: begin
            cmd.sum_add = 1'b1;
            cnt_in      = cnt_nxt;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = '0;
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_SCAN_CMP: begin
            cmd.cum_add = 1'b1;
            cnt_in      = cnt_nxt;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/fitness_proportionate_selector_core.sv -----
// top level of the fitness-proportionate selector: csr port, sequencer and datapath
// depends on fps_pkg, fps_req_if, fps_rsp_if, fps_ctrl and fps_datapath
//
// Roulette-wheel selector over 128 unsigned 16-bit weights. A load word writes one
// weight and gives no response. A draw word sums the first N weights,
// N = min(entry_count, 128), scales the sum by random_fraction to a threshold, then
// scans for the first entry whose running sum exceeds it; a zero sum returns index 0
// with all_zero_flag set. Both passes go through the single read port of the weight
// memory, each entry taking a read state and then an accumulate or compare state.
// The weights read as zero after reset with no clearing pass. The request side is
// taken again as soon as the response is parked in the output register.
// entry_count sits at byte address 0 and resets to 100.
module fitness_proportionate_selector_core (
   input  logic                              clock,
   input  logic                              reset,
   fps_req_if.sink                           req_ch,
   fps_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fps_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fps_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fps_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import fps_pkg::*;

   logic [CFG_BITS-1:0] entry_count_ff, entry_count_in;
   logic                csr_wr;
   fps_cmd_type         cmd;
   fps_stat_type        stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_wr && csr_paddr[2] == REG_ENTRY_COUNT) begin
         entry_count_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= CFG_BITS'(ENTRY_COUNT_RESET);
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ENTRY_COUNT) ? CSR_DATA_BITS'(entry_count_ff)
                                                         : '0;

   fps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .entry_count (entry_count_ff),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_type    (req_ch.req_type),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .stat        (stat)
   );

   fps_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_entry_index     (req_ch.entry_index),
      .req_weight_value    (req_ch.weight_value),
      .req_random_fraction (req_ch.random_fraction),
      .rsp_selected_index  (rsp_ch.selected_index),
      .rsp_all_zero_flag   (rsp_ch.all_zero_flag)
   );

endmodule

// ----- src/fps_checker.sv -----
// port-level checks on the selector's request and response words
// depends on fps_pkg; bound to fitness_proportionate_selector_core below
module fps_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_type,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [fps_pkg::IDX_BITS-1:0] rsp_selected_index,
   input logic                         rsp_all_zero_flag
);
   import fps_pkg::*;

   // a pending response word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a draw blocks the request side while it runs
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_DRAW |=> !req_ready)
      else $error("request taken during a draw");

   // a load completes in its accept cycle
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_LOAD |=> req_ready)
      else $error("load held the request side");

   // zero sum always reports index zero
   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_zero_flag |-> rsp_selected_index == '0)
      else $error("zero-sum response with nonzero index");

   // a new response only comes out of a running draw
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while idle");

endmodule

bind fitness_proportionate_selector_core fps_checker u_fps_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_type           (req_ch.req_type),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_selected_index (rsp_ch.selected_index),
   .rsp_all_zero_flag  (rsp_ch.all_zero_flag)
);
